@@ src/mbb_pkg.sv @@
// Package for the mask bounding box block: field widths, the foreground
// threshold and the configuration register indexes. No dependencies.
package mbb_pkg;

   // Field widths of the request, result and configuration data
   localparam int MASK_W     = 8;
   localparam int CFG_W      = 14;
   localparam int CROP_POS_W = 13;
   localparam int CROP_LEN_W = 14;
   localparam int CSR_IDX_W  = 2;

   // Mask bytes at or above this value are foreground
   localparam logic [MASK_W-1:0] FG_THRESHOLD = 8'd128;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PAD_AMOUNT   = 2'd2
   } csr_index_type;

endpackage

@@ src/mbb_if.sv @@
// Valid/ready channel interfaces for mask pixels and bounding box results.
// Depends on mbb_pkg for the field widths.
interface mbb_req_if;
   logic                        valid;
   logic                        ready;
   logic [mbb_pkg::MASK_W-1:0]  mask_value;

   modport source (output valid, output mask_value, input ready);
   modport sink   (input valid, input mask_value, output ready);
endinterface

interface mbb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [mbb_pkg::CROP_POS_W-1:0]  crop_x;
   logic [mbb_pkg::CROP_POS_W-1:0]  crop_y;
   logic [mbb_pkg::CROP_LEN_W-1:0]  crop_width;
   logic [mbb_pkg::CROP_LEN_W-1:0]  crop_height;

   modport source (output valid, output found, output crop_x, output crop_y,
                   output crop_width, output crop_height, input ready);
   modport sink   (input valid, input found, input crop_x, input crop_y,
                   input crop_width, input crop_height, output ready);
endinterface

@@ src/mask_bounding_box_top.sv @@
// Mask bounding box: finds the padded, clamped box around foreground pixels.
// Depends on mbb_pkg and the channel interfaces in mbb_if.sv.
//
// One mask byte is taken per clock while ready, in raster order; the block
// counts columns and rows itself from image_width and image_height (0 acts as
// 1, values above MAX_DIM act as MAX_DIM). Bytes of 128 or more are
// foreground. On a frame's last pixel its box is latched into a snapshot
// register; from it the padded, clamped crop box is registered in the result
// register once that is free. The throughput is one pixel per clock while
// results are taken, set by the per-pixel min/max update and counter step; a
// stalled result holds the snapshot and then the input. Frames as short as
// one pixel give one result per clock when not stalled. Configuration is
// written through csr_we/csr_index/csr_wdata; unknown indexes are ignored.
module mask_bounding_box_top #(
   parameter int MAX_DIM = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   mbb_req_if.sink                           req_bus,
   mbb_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [mbb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbb_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int EXT_W = ((CNT_W > mbb_pkg::CFG_W) ? CNT_W : mbb_pkg::CFG_W) + 1;
   localparam logic [EXT_W-1:0] MAX_DIM_EXT = EXT_W'(MAX_DIM);
   localparam logic [EXT_W-1:0] ONE_EXT     = EXT_W'(1);

   // Configuration registers
   logic [mbb_pkg::CFG_W-1:0] image_width_ff, image_height_ff, pad_amount_ff;

   // Frame state
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0] least_col_ff, least_col_in, least_row_ff, least_row_in;
   logic [CNT_W-1:0] great_col_ff, great_col_in, great_row_ff, great_row_in;
   logic             any_found_ff, any_found_in;

   // Snapshot of a finished frame
   logic             snap_valid_ff;
   logic             snap_found_ff;
   logic [CNT_W-1:0] snap_lo_col_ff, snap_hi_col_ff, snap_lo_row_ff, snap_hi_row_ff;

   // Result register
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff, rsp_found_in;
   logic [mbb_pkg::CROP_POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [mbb_pkg::CROP_LEN_W-1:0]  rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;

   logic             out_en, snap_en, accept;
   logic [EXT_W-1:0] eff_w, eff_h, pad_ext;
   logic             is_fg, col_last, row_last, frame_last, take_pix;
   logic [EXT_W-1:0] x_len, y_len;
   logic [EXT_W-1:0] x_start, y_start;

   // Clamp a configured dimension to 1..MAX_DIM
   function automatic logic [EXT_W-1:0] eff_dim(input logic [mbb_pkg::CFG_W-1:0] v);
      logic [EXT_W-1:0] v_ext;
      v_ext = EXT_W'(v);
      if (v_ext == '0) begin
         return ONE_EXT;
      end else if (v_ext > MAX_DIM_EXT) begin
         return MAX_DIM_EXT;
      end
      return v_ext;
   endfunction

   // Pad one axis of the box and clamp it to 0 and the image edge
   function automatic logic [2*EXT_W-1:0] extent(input logic [CNT_W-1:0] lo,
                                                  input logic [CNT_W-1:0] hi,
                                                  input logic [EXT_W-1:0] dim,
                                                  input logic [EXT_W-1:0] pad);
      logic [EXT_W-1:0] s, e, pe, lo_ext;
      lo_ext = EXT_W'(lo);
      s      = (lo_ext > pad) ? lo_ext - pad : '0;
      pe     = EXT_W'(hi) + pad + ONE_EXT;
      e      = (pe < dim) ? pe : dim;
      return {s, (e > s) ? e - s : EXT_W'(0)};
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mbb_pkg::CFG_W'(1);
         image_height_ff <= mbb_pkg::CFG_W'(1);
         pad_amount_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mbb_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            mbb_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            mbb_pkg::CSR_PAD_AMOUNT:   pad_amount_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_w   = eff_dim(image_width_ff);
   assign eff_h   = eff_dim(image_height_ff);
   assign pad_ext = EXT_W'(pad_amount_ff);

   // Pipeline enables: each stage advances when the one after it can take data
   assign out_en        = !rsp_valid_ff || rsp_bus.ready;
   assign snap_en       = !snap_valid_ff || out_en;
   assign req_bus.ready = snap_en;
   assign accept        = req_bus.valid && snap_en;

   // Per-pixel min/max update and raster counters
   always_comb begin
      is_fg      = req_bus.mask_value >= mbb_pkg::FG_THRESHOLD;
      take_pix   = is_fg;
      col_last   = EXT_W'(col_ff) >= eff_w - ONE_EXT;
      row_last   = EXT_W'(row_ff) >= eff_h - ONE_EXT;
      frame_last = col_last && row_last;

      any_found_in = any_found_ff || take_pix;
      least_col_in = (take_pix && (!any_found_ff || col_ff < least_col_ff)) ? col_ff
                                                                           : least_col_ff;
      least_row_in = (take_pix && (!any_found_ff || row_ff < least_row_ff)) ? row_ff
                                                                           : least_row_ff;
      great_col_in = (take_pix && (!any_found_ff || col_ff > great_col_ff)) ? col_ff
                                                                           : great_col_ff;
      great_row_in = (take_pix && (!any_found_ff || row_ff > great_row_ff)) ? row_ff
                                                                           : great_row_ff;

      col_in = col_last ? '0 : col_ff + CNT_W'(1);
      row_in = !col_last ? row_ff : (row_last ? '0 : row_ff + CNT_W'(1));
   end

   // Hold frame state; clear it after the frame's last pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         any_found_ff <= 1'b0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         any_found_ff <= frame_last ? 1'b0 : any_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         least_col_ff <= least_col_in;
         least_row_ff <= least_row_in;
         great_col_ff <= great_col_in;
         great_row_ff <= great_row_in;
      end
   end

   // Capture the finished frame box
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_en) begin
         snap_valid_ff <= accept && frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_last) begin
         snap_found_ff  <= any_found_in;
         snap_lo_col_ff <= least_col_in;
         snap_hi_col_ff <= great_col_in;
         snap_lo_row_ff <= least_row_in;
         snap_hi_row_ff <= great_row_in;
      end
   end

   // Pad and clamp the box; a frame with no foreground gives a zero box
   always_comb begin
      {x_start, x_len} = extent(snap_lo_col_ff, snap_hi_col_ff, eff_w, pad_ext);
      {y_start, y_len} = extent(snap_lo_row_ff, snap_hi_row_ff, eff_h, pad_ext);
      rsp_found_in = snap_found_ff;
      rsp_x_in     = snap_found_ff ? x_start[mbb_pkg::CROP_POS_W-1:0] : '0;
      rsp_y_in     = snap_found_ff ? y_start[mbb_pkg::CROP_POS_W-1:0] : '0;
      rsp_w_in     = snap_found_ff ? x_len[mbb_pkg::CROP_LEN_W-1:0] : '0;
      rsp_h_in     = snap_found_ff ? y_len[mbb_pkg::CROP_LEN_W-1:0] : '0;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && snap_valid_ff) begin
         rsp_found_ff <= rsp_found_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_w_ff     <= rsp_w_in;
         rsp_h_ff     <= rsp_h_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.crop_x      = rsp_x_ff;
   assign rsp_bus.crop_y      = rsp_y_ff;
   assign rsp_bus.crop_width  = rsp_w_ff;
   assign rsp_bus.crop_height = rsp_h_ff;

   // Nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   // A frame without foreground reports an all-zero box
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_w_ff == '0 && rsp_h_ff == '0))
      else $error("empty frame with nonzero box");

   // A captured frame moves to the result register when that register is free
   assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("snapshot not forwarded to result");

   // Frame state is cleared after the last pixel's transfer
   assert property (@(posedge clock) disable iff (reset)
      (accept && frame_last) |=> (col_ff == '0 && row_ff == '0 && !any_found_ff))
      else $error("frame state not cleared at frame end");

endmodule

@@ dv/mbb_tb_pkg.sv @@
// Scoreboard for the mask bounding box testbench: a pixel-level predictor of
// the frame box and a queue of expected crop boxes. Depends on mbb_pkg.
package mbb_tb_pkg;
   import mbb_pkg::*;

   localparam int unsigned MAX_DIM = 8192;
   localparam logic [CFG_W-1:0] LEAST_CLEAR = '1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                  found;
      logic [CROP_POS_W-1:0] crop_x;
      logic [CROP_POS_W-1:0] crop_y;
      logic [CROP_LEN_W-1:0] crop_width;
      logic [CROP_LEN_W-1:0] crop_height;
   } crop_box_t;

   function automatic string box_text(crop_box_t box);
      return $sformatf("found=%0d x=%0d y=%0d w=%0d h=%0d", box.found, box.crop_x,
                       box.crop_y, box.crop_width, box.crop_height);
   endfunction

   class bbox_scoreboard;
      logic [CFG_W-1:0]      image_width;
      logic [CFG_W-1:0]      image_height;
      logic [CFG_W-1:0]      pad_amount;
      logic [CROP_POS_W-1:0] column_count;
      logic [CROP_POS_W-1:0] row_count;
      logic [CFG_W-1:0]      least_column;
      logic [CFG_W-1:0]      least_row;
      logic [CROP_POS_W-1:0] greatest_column;
      logic [CROP_POS_W-1:0] greatest_row;
      logic                  any_found;
      crop_box_t             pending_boxes[$];
      int                    mismatches;

      function new();
         image_width  = 1;
         image_height = 1;
         pad_amount   = 0;
         mismatches   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         column_count    = 0;
         row_count       = 0;
         least_column    = LEAST_CLEAR;
         least_row       = LEAST_CLEAR;
         greatest_column = 0;
         greatest_row    = 0;
         any_found       = 1'b0;
      endfunction

      // Zero acts as one, anything past the largest frame acts as the largest
      function int unsigned used_dim(logic [CFG_W-1:0] value);
         if (value == 0) return 1;
         if (value > MAX_DIM) return MAX_DIM;
         return value;
      endfunction

      // Grow one axis of the box by the pad and clamp it to the image
      function void padded_extent(input int unsigned lo, input int unsigned hi,
                                  input int unsigned dim, input int unsigned pad,
                                  output int unsigned start, output int unsigned span);
         int unsigned stop;
         start = (lo > pad) ? lo - pad : 0;
         stop  = hi + pad + 1;
         if (stop > dim) stop = dim;
         span  = (stop > start) ? stop - start : 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_IMAGE_WIDTH:  image_width  = value;
            CSR_IMAGE_HEIGHT: image_height = value;
            CSR_PAD_AMOUNT:   pad_amount   = value;
            default: ;
         endcase
      endfunction

      // Advance the raster position by one pixel; return 1 when a frame closes
      function bit note_pixel(logic [MASK_W-1:0] mask_value);
         int unsigned w;
         int unsigned h;
         int unsigned cx;
         int unsigned cy;
         int unsigned cw;
         int unsigned ch;
         crop_box_t   box;
         w = used_dim(image_width);
         h = used_dim(image_height);
         if (mask_value >= FG_THRESHOLD) begin
            any_found = 1'b1;
            if (column_count < least_column) least_column = column_count;
            if (row_count < least_row) least_row = row_count;
            if (column_count > greatest_column) greatest_column = column_count;
            if (row_count > greatest_row) greatest_row = row_count;
         end
         if (column_count < w - 1) begin
            column_count++;
            return 1'b0;
         end
         column_count = 0;
         if (row_count < h - 1) begin
            row_count++;
            return 1'b0;
         end
         cx = 0;
         cy = 0;
         cw = 0;
         ch = 0;
         if (any_found) begin
            padded_extent(least_column, greatest_column, w, pad_amount, cx, cw);
            padded_extent(least_row, greatest_row, h, pad_amount, cy, ch);
         end
         box.found       = any_found;
         box.crop_x      = cx[CROP_POS_W-1:0];
         box.crop_y      = cy[CROP_POS_W-1:0];
         box.crop_width  = cw[CROP_LEN_W-1:0];
         box.crop_height = ch[CROP_LEN_W-1:0];
         pending_boxes.push_back(box);
         clear_frame();
         return 1'b1;
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", what);
      endfunction

      // Compare one result transfer against the oldest expected box
      function void check_box(crop_box_t seen);
         crop_box_t want;
         if (pending_boxes.size() == 0) begin
            note_mismatch({"unexpected result ", box_text(seen)});
            return;
         end
         want = pending_boxes.pop_front();
         if (seen.found !== want.found || seen.crop_x !== want.crop_x ||
             seen.crop_y !== want.crop_y || seen.crop_width !== want.crop_width ||
             seen.crop_height !== want.crop_height)
            note_mismatch({"expected ", box_text(want), ", got ", box_text(seen)});
      endfunction

      // Flag every expected box that never showed up
      function void close_out();
         while (pending_boxes.size() != 0)
            note_mismatch({"missing result ", box_text(pending_boxes.pop_front())});
      endfunction
   endclass

endpackage

@@ dv/testbench.sv @@
// Top-level testbench for mask_bounding_box_top: directed and random mask frames
// under random stalls, checked against mbb_tb_pkg's scoreboard. Depends on mbb_pkg.
module testbench;
   import mbb_pkg::*;
   import mbb_tb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_PIXELS = 1750;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   mbb_req_if req_bus();
   mbb_rsp_if rsp_bus();

   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             cycle_count   = 0;
   bit             frame_end;
   bbox_scoreboard sb;

   mask_bounding_box_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the result channel at random
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check every result transfer
   always @(posedge clock) begin : rsp_monitor
      crop_box_t seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.found       = rsp_bus.found;
         seen.crop_x      = rsp_bus.crop_x;
         seen.crop_y      = rsp_bus.crop_y;
         seen.crop_width  = rsp_bus.crop_width;
         seen.crop_height = rsp_bus.crop_height;
         sb.check_box(seen);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mask_bounding_box_top test failed");
         $finish;
      end
   end

   // Offer one pixel after a random gap and hold it until the transfer
   task automatic send_pixel(input logic [MASK_W-1:0] value, output bit closes_frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.mask_value <= MASK_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mask_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      closes_frame = sb.note_pixel(value);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   // Drain outstanding results, let the pipeline settle, then load all registers
   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] pad, input bit poke_unused);
      req_bus.valid <= 1'b0;
      while (sb.pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (poke_unused) write_csr(CSR_UNUSED, CFG_W'($urandom));
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_PAD_AMOUNT, pad);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return CFG_W'(0);
         1:       return CFG_W'(1);
         9:       return CFG_W'($urandom_range(9, 24));
         default: return CFG_W'($urandom_range(2, 8));
      endcase
   endfunction

   function automatic int pick_density();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         3:       return 60;
         default: return 100;
      endcase
   endfunction

   initial begin
      int               random_sent;
      int               burst;
      int               density;
      logic [CFG_W-1:0] pad;
      logic [MASK_W-1:0] value;

      sb = new();
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.mask_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      rsp_stall_pct = 72;

      // Threshold edges on one-pixel frames from the reset size
      send_pixel(8'd0, frame_end);
      send_pixel(8'd127, frame_end);
      send_pixel(8'd128, frame_end);
      send_pixel(8'd255, frame_end);

      // Zero dimensions act as one; an unknown register index is ignored
      configure(0, 0, 0, 1'b1);
      send_pixel(8'd200, frame_end);

      // Single foreground pixel inside a padded box
      configure(4, 3, 1, 1'b0);
      for (int i = 0; i < 12; i++) send_pixel((i == 6) ? 8'd128 : 8'd127, frame_end);

      // Width shrinks under a found box: the column extent collapses to zero
      configure(8, 2, 0, 1'b0);
      for (int i = 0; i < 8; i++) send_pixel((i == 7) ? 8'd255 : 8'd0, frame_end);
      configure(2, 2, 0, 1'b0);
      send_pixel(8'd0, frame_end);
      send_pixel(8'd0, frame_end);

      // Width shrinks below the running column: the row ends at once
      configure(8, 4, 0, 1'b0);
      for (int i = 0; i < 6; i++) send_pixel(MASK_W'($urandom), frame_end);
      configure(3, 2, 2, 1'b0);
      for (int i = 0; i < 4; i++) send_pixel(MASK_W'($urandom), frame_end);

      // Oversized width runs a long row; a narrower width then closes the frame
      configure(CFG_W'(16383), 2, 0, 1'b0);
      for (int i = 0; i < 30; i++)
         send_pixel((i == 0 || i == 29) ? 8'd255 : 8'($urandom_range(0, 127)), frame_end);
      configure(3, 2, 0, 1'b0);
      for (int i = 0; i < 4; i++) send_pixel(8'($urandom_range(0, 127)), frame_end);

      // Oversized height and pad; a shorter height then closes the frame
      configure(2, CFG_W'(16383), CFG_W'(16383), 1'b0);
      for (int i = 0; i < 24; i++)
         send_pixel((i == 5 || i == 20) ? 8'($urandom_range(128, 255))
                                        : 8'($urandom_range(0, 127)), frame_end);
      configure(2, 4, CFG_W'(16383), 1'b0);
      for (int i = 0; i < 2; i++) send_pixel(8'($urandom_range(0, 127)), frame_end);

      // Random frames; register changes land at arbitrary points in a frame
      random_sent = 0;
      density     = pick_density();
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent < RANDOM_PIXELS / 3) begin
            send_idle_pct = 32;
            rsp_stall_pct = 72;
         end else if (random_sent < 2 * RANDOM_PIXELS / 3) begin
            send_idle_pct = 72;
            rsp_stall_pct = 32;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         case ($urandom_range(7))
            0:       pad = 0;
            1:       pad = CFG_W'($urandom_range(8192, 16383));
            default: pad = CFG_W'($urandom_range(1, 5));
         endcase
         configure(pick_dim(), pick_dim(), pad, $urandom_range(3) == 0);
         burst = $urandom_range(40, 200);
         repeat (burst) begin
            value = ($urandom_range(99) < density) ? 8'($urandom_range(128, 255))
                                                   : 8'($urandom_range(0, 127));
            send_pixel(value, frame_end);
            random_sent++;
            if (frame_end) density = pick_density();
         end
      end

      // Drain the remaining results and wait out the pipeline
      req_bus.valid <= 1'b0;
      while (sb.pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0)
         $display("mask_bounding_box_top test passed");
      else
         $display("mask_bounding_box_top test failed");
      $finish;
   end

endmodule
